@@ src/lgcs_pkg.sv @@
`default_nettype none

package lgcs_pkg;

	// fixed field widths
	localparam int unsigned COL_W    = 64;
	localparam int unsigned CFG_W    = 7;
	localparam int unsigned ROWS_DEF = 64;
	localparam int unsigned CNT_W    = 4;

	// row count after reset
	localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(64);

	// b3/s23 neighbor counts
	localparam logic [CNT_W-1:0] BIRTH_CNT   = CNT_W'(3);
	localparam logic [CNT_W-1:0] SURVIVE_CNT = CNT_W'(2);

	// input word
	typedef struct packed {
		logic [COL_W-1:0] column_cells;
		logic             last_column;
	} lgcs_in_t;

	// output word
	typedef struct packed {
		logic [COL_W-1:0] next_cells;
		logic             last_of_board;
	} lgcs_out_t;

	// bits one cell shows its row neighbors, already masked
	typedef struct packed {
		logic left;
		logic mid;
		logic right;
	} lgcs_nbr_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic shift;
		logic clear;
		logic right_en;
	} lgcs_ctrl_t;

endpackage

`default_nettype wire

@@ src/lgcs_cell.sv @@
`default_nettype none

module lgcs_cell #(
	parameter int unsigned ROW_IDX = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  lgcs_pkg::lgcs_ctrl_t         ctrl,
	input  wire [lgcs_pkg::CFG_W-1:0]    rows_in_use,
	input  wire                          col_bit,
	input  lgcs_pkg::lgcs_nbr_t          up_nbr,
	input  lgcs_pkg::lgcs_nbr_t          dn_nbr,
	output lgcs_pkg::lgcs_nbr_t          own_nbr,
	output logic                         next_bit
);
	import lgcs_pkg::*;

	logic             older_q;
	logic             middle_q;
	logic             row_live;
	logic             col_m;
	logic [CNT_W-1:0] cnt;

	// row is inside the grid
	assign row_live = rows_in_use > CFG_W'(ROW_IDX);
	assign col_m    = col_bit & row_live;

	// masked bits handed to the rows above and below
	assign own_nbr.left  = older_q & row_live;
	assign own_nbr.mid   = middle_q & row_live;
	assign own_nbr.right = col_m & ctrl.right_en;

	// eight neighbors
	assign cnt = CNT_W'(up_nbr.left) + CNT_W'(up_nbr.mid) + CNT_W'(up_nbr.right)
	           + CNT_W'(dn_nbr.left) + CNT_W'(dn_nbr.mid) + CNT_W'(dn_nbr.right)
	           + CNT_W'(own_nbr.left) + CNT_W'(own_nbr.right);

	// birth on three, survival on two or three
	assign next_bit = row_live &
		((cnt == BIRTH_CNT) | (own_nbr.mid & (cnt == SURVIVE_CNT)));

	// column history for this row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q  <= 1'b0;
			middle_q <= 1'b0;
		end else if (ctrl.clear) begin
			older_q  <= 1'b0;
			middle_q <= 1'b0;
		end else if (ctrl.shift) begin
			older_q  <= middle_q;
			middle_q <= col_m;
		end
	end

endmodule

`default_nettype wire

@@ src/lgcs_obuf.sv @@
`default_nettype none

module lgcs_obuf (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  lgcs_pkg::lgcs_out_t   push_word,
	output logic                  full,
	output logic                  out_valid,
	input  wire                   out_stall,
	output lgcs_pkg::lgcs_out_t   out_word
);
	import lgcs_pkg::*;

	lgcs_out_t  buf_q [2];
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = count_q != 2'd0;
	assign out_word  = buf_q[0];
	assign full      = count_q == 2'd2;
	assign pop       = out_valid & ~out_stall;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push & ~pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop & ~push) begin
			count_q <= count_q - 2'd1;
		end
	end

	// head and skid entries
	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && count_q == 2'd1) begin
				buf_q[0] <= push_word;
			end else begin
				buf_q[0] <= buf_q[1];
			end
			if (push && count_q == 2'd2) begin
				buf_q[1] <= push_word;
			end
		end else if (push) begin
			buf_q[count_q[0]] <= push_word;
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) count_q != 2'd3;
	endproperty
	a_no_overflow: assert property (p_no_overflow)
		else $error("output queue count out of range");

	property p_push_fits;
		@(posedge clk) disable iff (!arst_n) push |-> (!full || pop);
	endproperty
	a_push_fits: assert property (p_push_fits)
		else $error("word pushed into a full output queue");

	property p_drain;
		@(posedge clk) disable iff (!arst_n)
			(count_q == 2'd2 && pop && !push) |=> count_q == 2'd1;
	endproperty
	a_drain: assert property (p_drain)
		else $error("output queue count lost track");

endmodule

`default_nettype wire

@@ src/life_generation_column_stream.sv @@
`default_nettype none
// results: a column's new generation is queued when the word that follows it is taken,
//   and the final column's own result is queued in the edge pass after it
// throughput: one column per cycle while the output queue is not full; the input stalls
//   during each board's edge pass, in which the row of cells evaluates the final column against an empty right edge
// reset (arst_n low, asynchronous): held columns clear to dead, rows_in_use returns to 64

module life_generation_column_stream #(
	parameter int unsigned ROWS = lgcs_pkg::ROWS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire [lgcs_pkg::CFG_W-1:0]    cfg_wr_data,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  lgcs_pkg::lgcs_in_t           in_word,
	output logic                         out_valid,
	input  wire                          out_stall,
	output lgcs_pkg::lgcs_out_t          out_word
);
	import lgcs_pkg::*;

	logic [CFG_W-1:0] rows_q;
	logic             held_q;
	logic             flush_q;
	logic             buf_full;
	logic             in_acc;
	logic             flush_fire;
	logic             produce;
	lgcs_ctrl_t       ctrl;
	lgcs_out_t        res_word;
	lgcs_nbr_t        nbr      [ROWS];
	logic [ROWS-1:0]  next_col;

	// row count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
		end else if (cfg_wr_en) begin
			rows_q <= cfg_wr_data;
		end
	end

	// handshake and cell control
	assign in_stall   = flush_q | buf_full;
	assign in_acc     = in_valid & ~in_stall;
	assign flush_fire = flush_q & ~buf_full;
	assign produce    = (in_acc & held_q) | flush_fire;

	assign ctrl.shift    = in_acc;
	assign ctrl.clear    = flush_fire;
	assign ctrl.right_en = ~flush_q;

	// board progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			flush_q <= 1'b0;
		end else if (flush_fire) begin
			held_q  <= 1'b0;
			flush_q <= 1'b0;
		end else if (in_acc) begin
			held_q  <= 1'b1;
			flush_q <= in_word.last_column;
		end
	end

	// one cell per row, neighbors chained by row
	for (genvar r = 0; r < ROWS; r++) begin : g_row
		lgcs_nbr_t up_n;
		lgcs_nbr_t dn_n;

		if (r == ROWS - 1) begin : g_top
			assign up_n = '0;
		end else begin : g_up
			assign up_n = nbr[r+1];
		end

		if (r == 0) begin : g_bot
			assign dn_n = '0;
		end else begin : g_dn
			assign dn_n = nbr[r-1];
		end

		lgcs_cell #(
			.ROW_IDX (r)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.rows_in_use (rows_q),
			.col_bit     (in_word.column_cells[r]),
			.up_nbr      (up_n),
			.dn_nbr      (dn_n),
			.own_nbr     (nbr[r]),
			.next_bit    (next_col[r])
		);
	end

	assign res_word.next_cells    = COL_W'(next_col);
	assign res_word.last_of_board = flush_fire;

	// result word queue
	lgcs_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (produce),
		.push_word (res_word),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	property p_last_flush;
		@(posedge clk) disable iff (!arst_n)
			(in_acc && in_word.last_column) |=> flush_q;
	endproperty
	a_last_flush: assert property (p_last_flush)
		else $error("final column did not start the edge pass");

	property p_flush_clears;
		@(posedge clk) disable iff (!arst_n) flush_fire |=> (!held_q && !flush_q);
	endproperty
	a_flush_clears: assert property (p_flush_clears)
		else $error("board state not cleared after final column");

	property p_flush_emits;
		@(posedge clk) disable iff (!arst_n)
			flush_fire |=> (out_valid && $past(res_word.last_of_board));
	endproperty
	a_flush_emits: assert property (p_flush_emits)
		else $error("final column result missing");

	property p_first_silent;
		@(posedge clk) disable iff (!arst_n) (in_acc && !held_q) |-> !produce;
	endproperty
	a_first_silent: assert property (p_first_silent)
		else $error("first column of a board produced a word");

endmodule

`default_nettype wire
